/* hw/rtl/rft_pkg.sv */
// Shared types and constants for the rail fence transposer.
// No dependencies; used by the top level.
package rft_pkg;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_DIV,
      ST_PREFIX,
      ST_EMIT,
      ST_DRAIN
   } state_type;

   typedef enum logic [1:0] {
      XF_COPY,
      XF_ENC,
      XF_DEC
   } xform_type;

   localparam logic [0:0] CSR_RAIL_COUNT   = 1'b0;
   localparam logic [0:0] CSR_DECRYPT_MODE = 1'b1;

   localparam int RAIL_W    = 7;
   localparam int BYTE_W    = 8;
   localparam int OUT_DEPTH = 4;
   localparam int OUT_PW    = 2;
   localparam int OUT_CW    = 3;

   localparam logic [RAIL_W-1:0] RAIL_RESET = 7'd4;

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              last;
      logic              ovf;
   } out_entry_type;

endpackage

/* hw/rtl/rail_fence_transposer_top.sv */
// Rail fence transposer: message buffer, rail pointer memory, address sequencer.
// Depends on rft_pkg (state, transform and output entry types).

// Bytes load one per cycle (req_ready high) until the transaction carrying
// req_in_last; req_ready then stays low until the last byte of the message has
// left the read pipeline. Copy and encrypt emit one byte per cycle while the
// output queue has room. Decrypt first divides the length by the zigzag period
// (2R-2) through repeated subtraction, then writes one rail start pointer per
// cycle, then emits one byte per cycle while the output queue has room. The
// one-byte-per-cycle emission rate is set by the single read port of the
// message memory and, for decrypt, by the read-modify-write of the rail pointer
// memory. A four-entry output queue lets results wait while the next message
// loads. Memories need no clearing pass after reset.
module rail_fence_transposer_top #(
   parameter int MAX_LEN = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_we,
   input  logic [0:0] csr_index,
   input  logic [6:0] csr_wdata,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       req_in_last,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_out_last,
   output logic       rsp_overflow
);

   localparam int SW  = $clog2(MAX_LEN + 1);
   localparam int AW  = $clog2(MAX_LEN);
   localparam int RD  = (MAX_LEN < 128) ? MAX_LEN : 128;
   localparam int RAW = (RD > 1) ? $clog2(RD) : 1;
   localparam int CW  = ((SW > 8) ? SW : 8) + 1;

   // configuration
   logic [6:0] rail_count_ff;
   logic       decrypt_mode_ff;

   // control state
   rft_pkg::state_type state_ff, state_in;
   rft_pkg::xform_type xf_ff, xf_in;
   logic [SW-1:0] count_ff, count_in;
   logic          ovf_ff, ovf_in;
   logic [SW-1:0] iss_ff, iss_in;

   // encrypt sequencer
   logic [6:0]    e_row_ff, e_row_in;
   logic [CW-1:0] e_pos_ff, e_pos_in;
   logic          e_mir_ff, e_mir_in;

   // decrypt zigzag, divider and prefix sum
   logic [6:0]    d_row_ff, d_row_in;
   logic          d_down_ff, d_down_in;
   logic [SW-1:0] q_ff, q_in;
   logic [SW-1:0] rm_ff, rm_in;
   logic [SW-1:0] acc_ff, acc_in;
   logic [6:0]    pr_ff, pr_in;

   // read pipeline
   logic           b_v_ff, b_v_in;
   logic           b_last_ff, b_last_in;
   logic [AW-1:0]  b_addr_ff, b_addr_in;
   logic [RAW-1:0] b_row_ff, b_row_in;
   logic           c_v_ff, c_last_ff;

   // memories
   logic [7:0]    msg_mem [MAX_LEN];
   logic [7:0]    msg_rd_ff;
   logic          msg_we;
   logic [AW-1:0] msg_wa, msg_ra;
   logic [SW-1:0] rail_mem [RD];
   logic [SW-1:0] rail_rd_ff;
   logic           rail_we;
   logic [RAW-1:0] rail_wa, rail_ra;
   logic [SW-1:0]  rail_wd;

   // output queue
   rft_pkg::out_entry_type ofifo_ff [rft_pkg::OUT_DEPTH];
   logic [rft_pkg::OUT_PW-1:0] owp_ff, orp_ff;
   logic [rft_pkg::OUT_CW-1:0] ocnt_ff;
   logic push, pop;

   // combinational helpers
   logic [7:0]    period8;
   logic [CW-1:0] period_w, size_w, mirror_w, cur_w, nxt_pos_w;
   logic [6:0]    rail_last;
   logic          inner_e, inner_p, full, plain, issue_ok, is_last_iss;
   logic [SW-1:0] size_new;
   logic [SW:0]   cnt_w;
   logic [6:0]    d_nxt;
   logic [3:0]    occ;

   always_ff @(posedge clock) begin
      if (reset) begin
         rail_count_ff   <= rft_pkg::RAIL_RESET;
         decrypt_mode_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            rft_pkg::CSR_RAIL_COUNT:   rail_count_ff   <= csr_wdata;
            rft_pkg::CSR_DECRYPT_MODE: decrypt_mode_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign period8   = {rail_count_ff, 1'b0} - 8'd2;
   assign period_w  = CW'(period8);
   assign size_w    = CW'(count_ff);
   assign rail_last = rail_count_ff - 7'd1;
   assign full      = (count_ff == SW'(MAX_LEN));
   assign size_new  = full ? count_ff : count_ff + SW'(1);
   assign plain     = (rail_count_ff <= 7'd1) || (CW'(rail_count_ff) >= CW'(size_new));

   // encrypt: walk rail by rail, inner rails also take the mirror position
   assign inner_e   = (e_row_ff != 7'd0) && (e_row_ff != rail_last);
   assign mirror_w  = e_pos_ff + period_w - CW'({e_row_ff, 1'b0});
   assign cur_w     = e_mir_ff ? mirror_w : e_pos_ff;
   assign nxt_pos_w = e_pos_ff + period_w;

   // decrypt: per rail count = q (twice on inner rails) plus remainder hits
   assign inner_p = (pr_ff != 7'd0) && (pr_ff != rail_last);
   assign cnt_w   = (inner_p ? {q_ff, 1'b0} : {1'b0, q_ff})
                  + (SW+1)'(CW'(rm_ff) > CW'(pr_ff))
                  + (SW+1)'(inner_p && (CW'(rm_ff) > (period_w - CW'(pr_ff))));

   assign d_nxt = d_down_ff ? d_row_ff + 7'd1 : d_row_ff - 7'd1;

   assign occ         = 4'(ocnt_ff) + 4'(b_v_ff) + 4'(c_v_ff);
   assign issue_ok    = occ < 4'(rft_pkg::OUT_DEPTH);
   assign is_last_iss = (iss_ff == count_ff - SW'(1));

   assign req_ready = (state_ff == rft_pkg::ST_LOAD);

   always_comb begin
      state_in  = state_ff;
      xf_in     = xf_ff;
      count_in  = count_ff;
      ovf_in    = ovf_ff;
      iss_in    = iss_ff;
      e_row_in  = e_row_ff;
      e_pos_in  = e_pos_ff;
      e_mir_in  = e_mir_ff;
      d_row_in  = d_row_ff;
      d_down_in = d_down_ff;
      q_in      = q_ff;
      rm_in     = rm_ff;
      acc_in    = acc_ff;
      pr_in     = pr_ff;
      b_v_in    = 1'b0;
      b_last_in = b_last_ff;
      b_addr_in = b_addr_ff;
      b_row_in  = b_row_ff;
      msg_we    = 1'b0;
      msg_wa    = count_ff[AW-1:0];
      rail_we   = 1'b0;
      rail_wa   = pr_ff[RAW-1:0];
      rail_wd   = acc_ff;
      rail_ra   = d_row_ff[RAW-1:0];

      case (state_ff)
         rft_pkg::ST_LOAD: begin
            if (req_valid) begin
               if (full) begin
                  ovf_in = 1'b1;
               end else begin
                  msg_we   = 1'b1;
                  count_in = count_ff + SW'(1);
               end
               if (req_in_last) begin
                  iss_in    = '0;
                  e_row_in  = '0;
                  e_pos_in  = '0;
                  e_mir_in  = 1'b0;
                  d_row_in  = '0;
                  d_down_in = 1'b1;
                  q_in      = '0;
                  rm_in     = size_new;
                  acc_in    = '0;
                  pr_in     = '0;
                  if (plain) begin
                     xf_in    = rft_pkg::XF_COPY;
                     state_in = rft_pkg::ST_EMIT;
                  end else if (decrypt_mode_ff) begin
                     xf_in    = rft_pkg::XF_DEC;
                     state_in = rft_pkg::ST_DIV;
                  end else begin
                     xf_in    = rft_pkg::XF_ENC;
                     state_in = rft_pkg::ST_EMIT;
                  end
               end
            end
         end
         rft_pkg::ST_DIV: begin
            if (CW'(rm_ff) >= period_w) begin
               rm_in = SW'(CW'(rm_ff) - period_w);
               q_in  = q_ff + SW'(1);
            end else begin
               state_in = rft_pkg::ST_PREFIX;
            end
         end
         rft_pkg::ST_PREFIX: begin
            rail_we = 1'b1;
            acc_in  = SW'({1'b0, acc_ff} + cnt_w);
            pr_in   = pr_ff + 7'd1;
            if (pr_ff == rail_last) state_in = rft_pkg::ST_EMIT;
         end
         rft_pkg::ST_EMIT: begin
            if (issue_ok) begin
               b_v_in    = 1'b1;
               b_last_in = is_last_iss;
               iss_in    = iss_ff + SW'(1);
               b_row_in  = d_row_ff[RAW-1:0];
               case (xf_ff)
                  rft_pkg::XF_COPY: b_addr_in = iss_ff[AW-1:0];
                  rft_pkg::XF_ENC: begin
                     b_addr_in = cur_w[AW-1:0];
                     if (!e_mir_ff && inner_e && (mirror_w < size_w)) begin
                        e_mir_in = 1'b1;
                     end else begin
                        e_mir_in = 1'b0;
                        if (nxt_pos_w < size_w) begin
                           e_pos_in = nxt_pos_w;
                        end else begin
                           e_row_in = e_row_ff + 7'd1;
                           e_pos_in = CW'(e_row_ff + 7'd1);
                        end
                     end
                  end
                  rft_pkg::XF_DEC: begin
                     d_row_in = d_nxt;
                     if ((d_nxt == 7'd0) || (d_nxt == rail_last)) d_down_in = !d_down_ff;
                  end
                  default: ;
               endcase
               if (is_last_iss) state_in = rft_pkg::ST_DRAIN;
            end
         end
         rft_pkg::ST_DRAIN: begin
            if (!b_v_ff && !c_v_ff) begin
               count_in = '0;
               ovf_in   = 1'b0;
               state_in = rft_pkg::ST_LOAD;
            end
         end
         default: state_in = rft_pkg::ST_LOAD;
      endcase

      // stage B: bump the rail pointer that was just read
      if (b_v_ff && (xf_ff == rft_pkg::XF_DEC)) begin
         rail_we = 1'b1;
         rail_wa = b_row_ff;
         rail_wd = rail_rd_ff + SW'(1);
      end
   end

   assign msg_ra = (xf_ff == rft_pkg::XF_DEC) ? rail_rd_ff[AW-1:0] : b_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= rft_pkg::ST_LOAD;
         xf_ff     <= rft_pkg::XF_COPY;
         count_ff  <= '0;
         ovf_ff    <= 1'b0;
         iss_ff    <= '0;
         e_row_ff  <= '0;
         e_pos_ff  <= '0;
         e_mir_ff  <= 1'b0;
         d_row_ff  <= '0;
         d_down_ff <= 1'b1;
         q_ff      <= '0;
         rm_ff     <= '0;
         acc_ff    <= '0;
         pr_ff     <= '0;
         b_v_ff    <= 1'b0;
         b_last_ff <= 1'b0;
         c_v_ff    <= 1'b0;
         c_last_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         xf_ff     <= xf_in;
         count_ff  <= count_in;
         ovf_ff    <= ovf_in;
         iss_ff    <= iss_in;
         e_row_ff  <= e_row_in;
         e_pos_ff  <= e_pos_in;
         e_mir_ff  <= e_mir_in;
         d_row_ff  <= d_row_in;
         d_down_ff <= d_down_in;
         q_ff      <= q_in;
         rm_ff     <= rm_in;
         acc_ff    <= acc_in;
         pr_ff     <= pr_in;
         b_v_ff    <= b_v_in;
         b_last_ff <= b_last_in;
         c_v_ff    <= b_v_ff;
         c_last_ff <= b_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      b_addr_ff <= b_addr_in;
      b_row_ff  <= b_row_in;
   end

   // message buffer: one write port (load), one read port (emission)
   always_ff @(posedge clock) begin
      if (msg_we) msg_mem[msg_wa] <= req_in_byte;
      msg_rd_ff <= msg_mem[msg_ra];
   end

   // rail pointers; a rail is never touched in two consecutive issues
   always_ff @(posedge clock) begin
      if (rail_we) rail_mem[rail_wa] <= rail_wd;
      rail_rd_ff <= rail_mem[rail_ra];
   end

   // output queue; space is reserved at issue so the pipeline never stalls
   assign push = c_v_ff;
   assign pop  = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (push) begin
         ofifo_ff[owp_ff].data <= msg_rd_ff;
         ofifo_ff[owp_ff].last <= c_last_ff;
         ofifo_ff[owp_ff].ovf  <= ovf_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         owp_ff  <= '0;
         orp_ff  <= '0;
         ocnt_ff <= '0;
      end else begin
         if (push) owp_ff <= owp_ff + rft_pkg::OUT_PW'(1);
         if (pop)  orp_ff <= orp_ff + rft_pkg::OUT_PW'(1);
         ocnt_ff <= ocnt_ff + rft_pkg::OUT_CW'(push) - rft_pkg::OUT_CW'(pop);
      end
   end

   assign rsp_valid    = (ocnt_ff != '0);
   assign rsp_out_byte = ofifo_ff[orp_ff].data;
   assign rsp_out_last = ofifo_ff[orp_ff].last;
   assign rsp_overflow = ofifo_ff[orp_ff].ovf;

endmodule

/* hw/rtl/rft_checker.sv */
// Port-level checks for the rail fence transposer, bound to its top level.
// Depends only on the top level's ports.
module rft_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       req_in_last,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_out_last,
   input logic       rsp_overflow
);

   // nothing queued right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a last-byte transaction ends loading for this message
   a_last_blocks: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_in_last |=> !req_ready)
      else $error("input still ready after last byte");

   // while loading, no new results appear
   a_load_quiet: assert property (@(posedge clock) disable iff (reset)
      req_ready && !rsp_valid |=> !rsp_valid)
      else $error("result appeared while loading");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte)
         && $stable(rsp_out_last) && $stable(rsp_overflow))
      else $error("stalled result changed");

endmodule

bind rail_fence_transposer_top rft_checker u_rft_checker (.*);
